// File: hw/rtl/cnc_pkg.sv
// Shared types, constants and reference color table for the nearest color classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package cnc_pkg;

    // Default raw count width
    localparam int COUNT_BITS_DEF = 16;

    // Normalized channel and result widths
    localparam int NORM_BITS   = 8;
    localparam int NUM_CHANS   = 3;
    localparam int CHAN_BITS   = 2;
    localparam int NUM_CLASSES = 9;
    localparam int CLASS_BITS  = 4;
    localparam int DIST_BITS   = 18;
    localparam int SCALE_BITS  = 7;
    localparam int NORM_SCALE  = 100;
    localparam int NORM_MAX    = 255;
    localparam int MAX_DIST    = 195075;

    // Output stream payload: color_class, min_distance, zero fill to bytes
    localparam int OUT_DATA_BITS = ((CLASS_BITS + DIST_BITS + 7) / 8) * 8;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int REG_IDX_BITS = 3;
    localparam logic [REG_IDX_BITS-1:0] REG_BLACK_RED   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_BLACK_GREEN = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_BLACK_BLUE  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_WHITE_RED   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_WHITE_GREEN = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_WHITE_BLUE  = 3'd5;

    // Calibration values after reset
    localparam int RST_BLACK_RED   = 1028;
    localparam int RST_BLACK_GREEN = 587;
    localparam int RST_BLACK_BLUE  = 161;
    localparam int RST_WHITE_RED   = 10492;
    localparam int RST_WHITE_GREEN = 6997;
    localparam int RST_WHITE_BLUE  = 1904;

    // Channel selectors
    localparam logic [CHAN_BITS-1:0] CHAN_RED   = 2'd0;
    localparam logic [CHAN_BITS-1:0] CHAN_GREEN = 2'd1;
    localparam logic [CHAN_BITS-1:0] CHAN_BLUE  = 2'd2;

    // Color classes
    localparam logic [CLASS_BITS-1:0] CLS_RED        = 4'd0;
    localparam logic [CLASS_BITS-1:0] CLS_GREEN      = 4'd1;
    localparam logic [CLASS_BITS-1:0] CLS_BLUE       = 4'd2;
    localparam logic [CLASS_BITS-1:0] CLS_YELLOW     = 4'd3;
    localparam logic [CLASS_BITS-1:0] CLS_PINK       = 4'd4;
    localparam logic [CLASS_BITS-1:0] CLS_ORANGE     = 4'd5;
    localparam logic [CLASS_BITS-1:0] CLS_LIGHT_BLUE = 4'd6;
    localparam logic [CLASS_BITS-1:0] CLS_WHITE      = 4'd7;
    localparam logic [CLASS_BITS-1:0] CLS_BLACK      = 4'd8;

    // One normalized sample
    typedef struct packed {
        logic [NORM_BITS-1:0] blue;
        logic [NORM_BITS-1:0] green;
        logic [NORM_BITS-1:0] red;
    } t_norm;

    // Front side of the queue
    typedef struct packed {
        logic  valid;
        t_norm data;
    } t_push;

    // Back side of the queue
    typedef struct packed {
        logic  valid;
        t_norm data;
    } t_pop;

    // Reference color of a class
    function automatic t_norm ref_color(input logic [CLASS_BITS-1:0] cls);
        t_norm c;
        begin
            unique case (cls)
                CLS_RED:        c = '{blue: 8'd2,   green: 8'd2,   red: 8'd72};
                CLS_GREEN:      c = '{blue: 8'd8,   green: 8'd54,  red: 8'd25};
                CLS_BLUE:       c = '{blue: 8'd36,  green: 8'd9,   red: 8'd3};
                CLS_YELLOW:     c = '{blue: 8'd20,  green: 8'd76,  red: 8'd93};
                CLS_PINK:       c = '{blue: 8'd64,  green: 8'd60,  red: 8'd77};
                CLS_ORANGE:     c = '{blue: 8'd28,  green: 8'd39,  red: 8'd92};
                CLS_LIGHT_BLUE: c = '{blue: 8'd84,  green: 8'd72,  red: 8'd38};
                CLS_WHITE:      c = '{blue: 8'd100, green: 8'd100, red: 8'd100};
                default:        c = '0;
            endcase
            return c;
        end
    endfunction

    // Pick one channel of a sample
    function automatic logic [NORM_BITS-1:0] chan_level(input t_norm s,
                                                         input logic [CHAN_BITS-1:0] ch);
        logic [NORM_BITS-1:0] v;
        begin
            unique case (ch)
                CHAN_RED:   v = s.red;
                CHAN_GREEN: v = s.green;
                default:    v = s.blue;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cnc_front.sv
// Front part: calibration registers, input transfer and per-channel normalization
// through one shared restoring divider. Depends on cnc_pkg.
`default_nettype none

module cnc_front #(
    parameter int COUNT_BITS = cnc_pkg::COUNT_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [COUNT_BITS-1:0]             i_red,
    input  wire  [COUNT_BITS-1:0]             i_green,
    input  wire  [COUNT_BITS-1:0]             i_blue,
    input  wire                               i_cfg_we,
    input  wire  [cnc_pkg::REG_IDX_BITS-1:0]  i_cfg_index,
    input  wire  [COUNT_BITS-1:0]             i_cfg_data,
    output cnc_pkg::t_push                    o_push,
    input  wire                               i_full
);
    import cnc_pkg::*;

    localparam int NUM_BITS = COUNT_BITS + SCALE_BITS;
    localparam int REM_BITS = COUNT_BITS + NORM_BITS;
    localparam int K_BITS   = $clog2(NORM_BITS);
    localparam logic [CHAN_BITS-1:0] LAST_CH = CHAN_BITS'(NUM_CHANS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_SAT  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [COUNT_BITS-1:0] r_black [NUM_CHANS];
    logic [COUNT_BITS-1:0] r_white [NUM_CHANS];
    logic [COUNT_BITS-1:0] r_raw   [NUM_CHANS];
    logic [NORM_BITS-1:0]  r_norm  [NUM_CHANS];

    logic [2:0]            r_state, n_state;
    logic [CHAN_BITS-1:0]  r_ch,    n_ch;
    logic [K_BITS-1:0]     r_k,     n_k;
    logic [NUM_BITS-1:0]   r_num,   n_num;
    logic [COUNT_BITS-1:0] r_den,   n_den;
    logic                  r_zero,  n_zero;
    logic [REM_BITS-1:0]   r_rem,   n_rem;
    logic [NORM_BITS-1:0]  r_q,     n_q;

    logic [COUNT_BITS-1:0] w_raw, w_black, w_white, w_diff;
    logic [NUM_BITS-1:0]   w_prod;
    logic [REM_BITS-1:0]   w_den_full, w_trial;
    logic                  w_ge, w_fin, w_accept;

    // Calibration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black[0] <= COUNT_BITS'(RST_BLACK_RED);
            r_black[1] <= COUNT_BITS'(RST_BLACK_GREEN);
            r_black[2] <= COUNT_BITS'(RST_BLACK_BLUE);
            r_white[0] <= COUNT_BITS'(RST_WHITE_RED);
            r_white[1] <= COUNT_BITS'(RST_WHITE_GREEN);
            r_white[2] <= COUNT_BITS'(RST_WHITE_BLUE);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BLACK_RED:   r_black[0] <= i_cfg_data;
                REG_BLACK_GREEN: r_black[1] <= i_cfg_data;
                REG_BLACK_BLUE:  r_black[2] <= i_cfg_data;
                REG_WHITE_RED:   r_white[0] <= i_cfg_data;
                REG_WHITE_GREEN: r_white[1] <= i_cfg_data;
                REG_WHITE_BLUE:  r_white[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // Operands of the channel in work
    assign w_raw      = r_raw[r_ch];
    assign w_black    = r_black[r_ch];
    assign w_white    = r_white[r_ch];
    assign w_diff     = w_raw - w_black;
    assign w_prod     = NUM_BITS'(w_diff) * NUM_BITS'(NORM_SCALE);
    assign w_den_full = {r_den, {NORM_BITS{1'b0}}};
    assign w_trial    = REM_BITS'(r_den) << r_k;
    assign w_ge       = (r_rem >= w_trial);

    // Normalization sequencer: scale, saturation check, one quotient bit a cycle
    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_k     = r_k;
        n_num   = r_num;
        n_den   = r_den;
        n_zero  = r_zero;
        n_rem   = r_rem;
        n_q     = r_q;
        w_fin   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_PREP;
                    n_ch    = '0;
                end
            end
            S_PREP: begin
                n_num   = w_prod;
                n_den   = w_white - w_black;
                n_zero  = (w_white <= w_black) || (w_raw < w_black);
                n_state = S_SAT;
            end
            S_SAT: begin
                n_rem = REM_BITS'(r_num);
                n_k   = K_BITS'(NORM_BITS - 1);
                n_q   = '0;
                if (r_zero) begin
                    w_fin = 1'b1;
                end else if (REM_BITS'(r_num) >= w_den_full) begin
                    n_q   = NORM_BITS'(NORM_MAX);
                    w_fin = 1'b1;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_ge) begin
                    n_rem      = r_rem - w_trial;
                    n_q[r_k]   = 1'b1;
                end
                if (r_k == '0) begin
                    w_fin = 1'b1;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // Advance to the next channel or hand the sample on
        if (w_fin) begin
            if (r_ch == LAST_CH) begin
                n_state = S_PUSH;
            end else begin
                n_ch    = r_ch + 1'b1;
                n_state = S_PREP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_num  <= n_num;
        r_den  <= n_den;
        r_zero <= n_zero;
        r_rem  <= n_rem;
        r_q    <= n_q;
        if (w_accept) begin
            r_raw[0] <= i_red;
            r_raw[1] <= i_green;
            r_raw[2] <= i_blue;
        end
        if (w_fin) begin
            r_norm[r_ch] <= n_q;
        end
    end

    assign o_push.valid      = (r_state == S_PUSH);
    assign o_push.data.red   = r_norm[0];
    assign o_push.data.green = r_norm[1];
    assign o_push.data.blue  = r_norm[2];

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_PREP) && (r_ch == '0))
        else $error("front did not start on the first channel");
    a_push_last_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> (r_ch == LAST_CH))
        else $error("sample offered before all channels were normalized");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < w_den_full) && !r_zero)
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/cnc_queue.sv
// Short queue of normalized samples between the front and back parts.
// Depends on cnc_pkg.
`default_nettype none

module cnc_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  cnc_pkg::t_push i_push,
    output logic           o_full,
    output cnc_pkg::t_pop  o_pop,
    input  wire            i_pop_ready
);
    import cnc_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

    t_norm               r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr, n_wr;
    logic [PTR_BITS-1:0] r_rd, n_rd;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                w_push, w_pop;

    assign o_full      = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_pop.valid = (r_count != '0);
    assign o_pop.data  = r_mem[r_rd];
    assign w_push      = i_push.valid && !o_full;
    assign w_pop       = o_pop.valid && i_pop_ready;

    // Pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue fill count overflow");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue push lost");
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue pop lost");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/cnc_back.sv
// Back part: squared distance to each reference color, one channel a cycle,
// running minimum and the output register. Depends on cnc_pkg.
`default_nettype none

module cnc_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  cnc_pkg::t_pop                      i_pop,
    output logic                               o_pop_ready,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    output logic [cnc_pkg::CLASS_BITS-1:0]     o_class,
    output logic [cnc_pkg::DIST_BITS-1:0]      o_dist
);
    import cnc_pkg::*;

    localparam logic [CHAN_BITS-1:0]  LAST_CH  = CHAN_BITS'(NUM_CHANS - 1);
    localparam logic [CLASS_BITS-1:0] LAST_CLS = CLASS_BITS'(NUM_CLASSES - 1);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RUN  = 2'd1;
    localparam logic [1:0] B_DONE = 2'd2;

    logic [1:0]            r_state, n_state;
    t_norm                 r_entry, n_entry;
    logic [CLASS_BITS-1:0] r_cls, n_cls;
    logic [CHAN_BITS-1:0]  r_chan, n_chan;
    logic [DIST_BITS-1:0]  r_acc, n_acc;
    logic [CLASS_BITS-1:0] r_best_cls, n_best_cls;
    logic [DIST_BITS-1:0]  r_best_dist, n_best_dist;
    logic                  r_out_valid;
    logic [CLASS_BITS-1:0] r_out_cls;
    logic [DIST_BITS-1:0]  r_out_dist;

    logic [NORM_BITS-1:0]   w_sample, w_ref, w_err;
    logic [2*NORM_BITS-1:0] w_sq;
    logic [DIST_BITS-1:0]   w_sum;
    logic                   w_out_free, w_load;

    assign o_pop_ready = (r_state == B_IDLE);
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_load      = (r_state == B_DONE) && w_out_free;

    // One squared channel error per cycle
    assign w_sample = chan_level(r_entry, r_chan);
    assign w_ref    = chan_level(ref_color(r_cls), r_chan);
    assign w_err    = (w_sample >= w_ref) ? w_sample - w_ref : w_ref - w_sample;
    assign w_sq     = w_err * w_err;
    assign w_sum    = r_acc + DIST_BITS'(w_sq);

    // Class sweep with first-wins minimum
    always_comb begin
        n_state     = r_state;
        n_entry     = r_entry;
        n_cls       = r_cls;
        n_chan      = r_chan;
        n_acc       = r_acc;
        n_best_cls  = r_best_cls;
        n_best_dist = r_best_dist;
        unique case (r_state)
            B_IDLE: begin
                if (i_pop.valid) begin
                    n_entry = i_pop.data;
                    n_cls   = '0;
                    n_chan  = '0;
                    n_acc   = '0;
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (r_chan == LAST_CH) begin
                    n_chan = '0;
                    n_acc  = '0;
                    if ((r_cls == '0) || (w_sum < r_best_dist)) begin
                        n_best_dist = w_sum;
                        n_best_cls  = r_cls;
                    end
                    if (r_cls == LAST_CLS) begin
                        n_state = B_DONE;
                    end else begin
                        n_cls = r_cls + 1'b1;
                    end
                end else begin
                    n_acc  = w_sum;
                    n_chan = r_chan + 1'b1;
                end
            end
            B_DONE: begin
                if (w_out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath and output payload registers
    always_ff @(posedge i_clk) begin
        r_entry     <= n_entry;
        r_cls       <= n_cls;
        r_chan      <= n_chan;
        r_acc       <= n_acc;
        r_best_cls  <= n_best_cls;
        r_best_dist <= n_best_dist;
        if (w_load) begin
            r_out_cls  <= r_best_cls;
            r_out_dist <= r_best_dist;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_class         = r_out_cls;
    assign o_dist          = r_out_dist;

`ifndef SYNTHESIS
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cls <= LAST_CLS))
        else $error("class index out of range");
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dist <= DIST_BITS'(MAX_DIST)))
        else $error("distance above the largest possible value");
    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop.valid && o_pop_ready) |=> (r_state == B_RUN) && (r_cls == '0))
        else $error("back did not start the class sweep");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/color_nearest_class_unit.sv
// Top level of the nearest color classifier: front normalizer, sample queue, distance back end.
// Depends on cnc_pkg, cnc_front, cnc_queue and cnc_back.
//
// Each input transfer carries raw red, green and blue counts; each is scaled against its
// black and white calibration counts to 0..255 (floor of (raw-black)*100/(white-black)), and
// the block returns the nearest of nine reference colors with its squared distance, one
// result per input, lowest class winning a tie. The front part takes a new sample only after
// it has handed the last one to the queue: one shared restoring divider normalizes the three
// channels in turn (scale, saturation check, eight quotient bits), and a channel with raw
// below black, white not above black or a saturated ratio finishes at the saturation check.
// The back part sweeps one channel and reference color at a time after the pop, then hands
// the result to the output register, and runs concurrently with the front through a
// two-entry queue. Calibration registers are to be written through i_cfg_we/i_cfg_index/
// i_cfg_data only while no sample is in flight; the block itself does not enforce this.
`default_nettype none

module color_nearest_class_unit #(
    parameter int COUNT_BITS = cnc_pkg::COUNT_BITS_DEF
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire                                       i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // red_count, green_count, blue_count from bit 0 up, zero fill to bytes
    input  wire  [((3*COUNT_BITS+7)/8)*8-1:0]         i_s_axis_tdata,
    output logic                                      o_m_axis_tvalid,
    input  wire                                       i_m_axis_tready,
    // color_class, min_distance from bit 0 up, zero fill to bytes
    output logic [cnc_pkg::OUT_DATA_BITS-1:0]         o_m_axis_tdata,
    input  wire                                       i_cfg_we,
    input  wire  [cnc_pkg::REG_IDX_BITS-1:0]          i_cfg_index,
    input  wire  [COUNT_BITS-1:0]                     i_cfg_data
);
    import cnc_pkg::*;

    t_push                 w_push;
    t_pop                  w_pop;
    logic                  w_full;
    logic                  w_pop_ready;
    logic [CLASS_BITS-1:0] w_class;
    logic [DIST_BITS-1:0]  w_dist;

    // Normalize incoming samples
    cnc_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_red           (i_s_axis_tdata[COUNT_BITS-1:0]),
        .i_green         (i_s_axis_tdata[2*COUNT_BITS-1:COUNT_BITS]),
        .i_blue          (i_s_axis_tdata[3*COUNT_BITS-1:2*COUNT_BITS]),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_push          (w_push),
        .i_full          (w_full)
    );

    // Decouple front and back
    cnc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_full      (w_full),
        .o_pop       (w_pop),
        .i_pop_ready (w_pop_ready)
    );

    // Classify by minimum distance
    cnc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pop           (w_pop),
        .o_pop_ready     (w_pop_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_class         (w_class),
        .o_dist          (w_dist)
    );

    assign o_m_axis_tdata = OUT_DATA_BITS'({w_dist, w_class});

endmodule

`default_nettype wire
